// ----- sv/lmo_pkg.sv -----
// Shared constants, command codes and handshake structs for the logistic map oscillator.
// No dependencies; imported by lmo_ctrl, lmo_dp and logistic_map_oscillator.
`default_nettype none

package lmo_pkg;

    localparam int EXP_TABLE_BITS = 8;
    localparam int EXP_N          = 1 << EXP_TABLE_BITS;
    localparam int EXP_SH         = 16 - EXP_TABLE_BITS;

    localparam int C4_Q16    = 17145893;
    localparam int ONE_Q24   = 16777216;
    localparam int X_INIT    = 1677722;

    localparam logic [31:0] DELTA_MIN = 32'd4295;
    localparam logic [31:0] DELTA_MAX = 32'd1503238554;

    localparam int IN_TDATA_W  = 64;
    localparam int IN_TUSER_W  = 1;
    localparam int OUT_TDATA_W = 24;
    localparam int OUT_TUSER_W = 1;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 31;

    localparam logic [CFG_IDX_W-1:0] CFG_R_KNOB        = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PITCH_KNOB    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VOL_KNOB      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_PERIOD = 2'd3;

    typedef enum logic [3:0] {
        MUL_NONE,
        MUL_DIV3,
        MUL_INTERP,
        MUL_MSP,
        MUL_QL,
        MUL_QH,
        MUL_XX,
        MUL_TL,
        MUL_TH,
        MUL_LERP,
        MUL_OL,
        MUL_OH
    } t_mul;

    typedef enum logic [3:0] {
        CAP_NONE,
        CAP_LOAD,
        CAP_OCT,
        CAP_TAB,
        CAP_MANT,
        CAP_Q,
        CAP_PL,
        CAP_PSUM,
        CAP_DELTA,
        CAP_PHASE,
        CAP_T,
        CAP_ACC,
        CAP_XSAT,
        CAP_LERP,
        CAP_OUT
    } t_cap;

    typedef struct packed {
        t_mul mul;
        t_cap cap;
    } t_cmd;

    typedef struct packed {
        logic conn;
        logic wrap;
    } t_stat;

endpackage

`default_nettype wire

// ----- sv/lmo_ctrl.sv -----
// Sequencer for the logistic map oscillator: steps one request through the datapath.
// Depends on lmo_pkg; drives lmo_dp through t_cmd and reads t_stat back.
`default_nettype none

module lmo_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output lmo_pkg::t_cmd      o_cmd,
    input  wire lmo_pkg::t_stat i_stat
);
    import lmo_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_OCT,
        ST_TAB,
        ST_INT,
        ST_MANT,
        ST_MSP,
        ST_Q,
        ST_QL,
        ST_QH,
        ST_PSUM,
        ST_DELTA,
        ST_PHASE,
        ST_XX,
        ST_T,
        ST_TL,
        ST_TH,
        ST_XSAT,
        ST_LRP,
        ST_LCAP,
        ST_OL,
        ST_OH,
        ST_OUT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   out_free;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd   = '{mul: MUL_NONE, cap: CAP_NONE};
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd   = '{mul: MUL_DIV3, cap: CAP_LOAD};
                    n_state = ST_OCT;
                end
            end
            ST_OCT: begin
                o_cmd.cap = CAP_OCT;
                n_state   = ST_TAB;
            end
            ST_TAB: begin
                o_cmd.cap = CAP_TAB;
                n_state   = ST_INT;
            end
            ST_INT: begin
                o_cmd.mul = MUL_INTERP;
                n_state   = ST_MANT;
            end
            ST_MANT: begin
                o_cmd.cap = CAP_MANT;
                n_state   = ST_MSP;
            end
            ST_MSP: begin
                o_cmd.mul = MUL_MSP;
                n_state   = ST_Q;
            end
            ST_Q: begin
                o_cmd.cap = CAP_Q;
                n_state   = ST_QL;
            end
            ST_QL: begin
                o_cmd.mul = MUL_QL;
                n_state   = ST_QH;
            end
            ST_QH: begin
                o_cmd   = '{mul: MUL_QH, cap: CAP_PL};
                n_state = ST_PSUM;
            end
            ST_PSUM: begin
                o_cmd.cap = CAP_PSUM;
                n_state   = ST_DELTA;
            end
            ST_DELTA: begin
                o_cmd.cap = CAP_DELTA;
                n_state   = ST_PHASE;
            end
            ST_PHASE: begin
                o_cmd.cap = CAP_PHASE;
                if (!i_stat.conn) begin
                    n_state = ST_OUT;
                end else if (i_stat.wrap) begin
                    n_state = ST_XX;
                end else begin
                    n_state = ST_LRP;
                end
            end
            ST_XX: begin
                o_cmd.mul = MUL_XX;
                n_state   = ST_T;
            end
            ST_T: begin
                o_cmd.cap = CAP_T;
                n_state   = ST_TL;
            end
            ST_TL: begin
                o_cmd.mul = MUL_TL;
                n_state   = ST_TH;
            end
            ST_TH: begin
                o_cmd   = '{mul: MUL_TH, cap: CAP_ACC};
                n_state = ST_XSAT;
            end
            ST_XSAT: begin
                o_cmd.cap = CAP_XSAT;
                n_state   = ST_LRP;
            end
            ST_LRP: begin
                o_cmd.mul = MUL_LERP;
                n_state   = ST_LCAP;
            end
            ST_LCAP: begin
                o_cmd.cap = CAP_LERP;
                n_state   = ST_OL;
            end
            ST_OL: begin
                o_cmd.mul = MUL_OL;
                n_state   = ST_OH;
            end
            ST_OH: begin
                o_cmd   = '{mul: MUL_OH, cap: CAP_ACC};
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (out_free) begin
                    o_cmd.cap = CAP_OUT;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// ----- sv/lmo_dp.sv -----
// Datapath of the logistic map oscillator: settings, state, exp2 table and one shared multiplier.
// Depends on lmo_pkg; sequenced by lmo_ctrl through t_cmd.
`default_nettype none

module lmo_dp (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_cfg_we,
    input  wire logic [lmo_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  wire logic [lmo_pkg::CFG_DATA_W-1:0]       i_cfg_wdata,
    input  wire logic [lmo_pkg::IN_TDATA_W-1:0]       i_in_data,
    input  wire logic [lmo_pkg::IN_TUSER_W-1:0]       i_in_user,
    input  wire lmo_pkg::t_cmd                        i_cmd,
    output lmo_pkg::t_stat                            o_stat,
    output logic [lmo_pkg::OUT_TDATA_W-1:0]           o_out_sample,
    output logic                                      o_out_flag
);
    import lmo_pkg::*;

    typedef logic [31:0] t_exp_tab [0:EXP_N];

    function automatic logic [31:0] isqrt64(input logic [63:0] v);
        logic [63:0] rem_v;
        logic [63:0] res;
        logic [63:0] b_m;
        rem_v = v;
        res   = '0;
        b_m   = 64'd1 << 62;
        while (b_m > rem_v) begin
            b_m = b_m >> 2;
        end
        while (b_m != 64'd0) begin
            if (rem_v >= res + b_m) begin
                rem_v = rem_v - (res + b_m);
                res   = (res >> 1) + b_m;
            end else begin
                res = res >> 1;
            end
            b_m = b_m >> 2;
        end
        return res[31:0];
    endfunction

    // Each midpoint is the geometric mean of its two neighbors, coarse strides first.
    function automatic t_exp_tab build_exp_tab();
        t_exp_tab tab;
        int       stride;
        int       h;
        int       i;
        for (i = 0; i <= EXP_N; i++) begin
            tab[i] = '0;
        end
        tab[0]     = 32'h4000_0000;
        tab[EXP_N] = 32'h8000_0000;
        for (stride = EXP_N; stride > 1; stride = stride >> 1) begin
            h = stride >> 1;
            for (i = h; i < EXP_N; i = i + stride) begin
                tab[i] = isqrt64({32'b0, tab[i-h]} * {32'b0, tab[i+h]});
            end
        end
        return tab;
    endfunction

    localparam t_exp_tab          EXP_TAB    = build_exp_tab();
    localparam logic signed [32:0] DIV3_RECIP = 33'h0_AAAA_AAAB;
    localparam logic signed [32:0] C4_OP      = 33'(C4_Q16);
    localparam logic signed [32:0] ONE_OP     = 33'(ONE_Q24);
    localparam logic signed [41:0] OUT_OFS    = 42'(5 * ONE_Q24);

    // Settings.
    logic [18:0]        r_rk;
    logic signed [15:0] r_pk;
    logic [19:0]        r_vk;
    logic [30:0]        r_sp;

    // Oscillator state.
    logic [31:0]        r_phase;
    logic signed [31:0] r_xc;
    logic signed [31:0] r_xp;
    logic               r_btn_high;

    // Per-request working registers.
    logic signed [20:0] r_pcv;
    logic signed [21:0] r_rsum;
    logic signed [21:0] r_gsum;
    logic               r_conn;
    logic               r_trig;
    logic signed [22:0] r_oct;
    logic signed [6:0]  r_n;
    logic [EXP_SH-1:0]  r_rem;
    logic [31:0]        r_tab0;
    logic [31:0]        r_tab1;
    logic [31:0]        r_mant;
    logic [37:0]        r_q;
    logic [63:0]        r_p;
    logic [31:0]        r_delta;
    logic signed [41:0] r_w;
    logic signed [65:0] r_prod;
    logic signed [65:0] r_acc;
    logic [23:0]        r_out_sample;
    logic               r_out_flag;

    // Input fields.
    logic signed [20:0] in_r_cv;
    logic signed [20:0] in_pitch_cv;
    logic signed [20:0] in_vol_cv;
    logic               in_btn;

    assign in_r_cv     = i_in_data[20:0];
    assign in_pitch_cv = i_in_data[41:21];
    assign in_vol_cv   = i_in_data[62:42];
    assign in_btn      = i_in_data[63];

    // Shared multiplier.
    logic signed [32:0] ma;
    logic signed [32:0] mb;
    logic signed [65:0] mul_p;
    logic signed [16:0] pk_ext;
    logic [16:0]        pk_mag;

    assign pk_ext = {r_pk[15], r_pk};
    assign pk_mag = r_pk[15] ? 17'(-pk_ext) : 17'(pk_ext);

    always_comb begin
        ma = '0;
        mb = '0;
        unique case (i_cmd.mul)
            MUL_NONE: begin
            end
            MUL_DIV3: begin
                ma = {10'b0, pk_mag, 6'b0};
                mb = DIV3_RECIP;
            end
            MUL_INTERP: begin
                ma = {1'b0, r_tab1 - r_tab0};
                mb = {{(33-EXP_SH){1'b0}}, r_rem};
            end
            MUL_MSP: begin
                ma = {1'b0, r_mant};
                mb = {2'b0, r_sp};
            end
            MUL_QL: begin
                ma = {1'b0, r_q[31:0]};
                mb = C4_OP;
            end
            MUL_QH: begin
                ma = {27'b0, r_q[37:32]};
                mb = C4_OP;
            end
            MUL_XX: begin
                ma = {r_xc[31], r_xc};
                mb = ONE_OP - {r_xc[31], r_xc};
            end
            MUL_TL: begin
                ma = {1'b0, r_w[31:0]};
                mb = {{11{r_rsum[21]}}, r_rsum};
            end
            MUL_TH: begin
                ma = {{23{r_w[41]}}, r_w[41:32]};
                mb = {{11{r_rsum[21]}}, r_rsum};
            end
            MUL_LERP: begin
                ma = {r_xc[31], r_xc} - {r_xp[31], r_xp};
                mb = {9'b0, r_phase[31:8]};
            end
            MUL_OL: begin
                ma = {1'b0, r_w[31:0]};
                mb = {{11{r_gsum[21]}}, r_gsum};
            end
            MUL_OH: begin
                ma = {{23{r_w[41]}}, r_w[41:32]};
                mb = {{11{r_gsum[21]}}, r_gsum};
            end
            default: begin
            end
        endcase
    end

    assign mul_p = ma * mb;

    // Octave value: truncated pitch_knob*256/12 plus the pitch voltage.
    logic [20:0]        div_q;
    logic signed [22:0] oct_div;
    logic signed [22:0] oct_sum;

    assign div_q   = r_prod[53:33];
    assign oct_div = r_pk[15] ? -$signed({2'b0, div_q}) : $signed({2'b0, div_q});
    assign oct_sum = oct_div + $signed({{2{r_pcv[20]}}, r_pcv});

    logic [EXP_TABLE_BITS-1:0] tab_i0;
    logic [EXP_TABLE_BITS:0]   tab_i1;

    assign tab_i0 = r_oct[15 -: EXP_TABLE_BITS];
    assign tab_i1 = {1'b0, tab_i0} + (EXP_TABLE_BITS+1)'(1);

    // Phase increment: scale by two to the integer octave minus 22, then clamp.
    logic signed [7:0] dl_e;
    logic [7:0]        dl_ne;
    logic [63:0]       dl_d;
    logic [31:0]       dl_c;

    assign dl_e  = {r_n[6], r_n} - 8'sd22;
    assign dl_ne = 8'(-dl_e);

    always_comb begin
        if (!dl_e[7]) begin
            if (dl_e >= 8'sd63 || r_p > (64'(DELTA_MAX) >> dl_e[5:0])) begin
                dl_d = 64'(DELTA_MAX);
            end else begin
                dl_d = r_p << dl_e[5:0];
            end
        end else if (dl_ne >= 8'd63) begin
            dl_d = '0;
        end else begin
            dl_d = r_p >> dl_ne[5:0];
        end
        if (dl_d < 64'(DELTA_MIN)) begin
            dl_c = DELTA_MIN;
        end else if (dl_d > 64'(DELTA_MAX)) begin
            dl_c = DELTA_MAX;
        end else begin
            dl_c = dl_d[31:0];
        end
    end

    logic [32:0] ph_sum;

    assign ph_sum = {1'b0, r_phase} + {1'b0, r_delta};

    // Wide products are assembled from a low and a high pass.
    logic signed [65:0] w_sum;
    logic signed [49:0] x_wide;
    logic signed [31:0] x_sat;
    logic signed [41:0] y_wide;
    logic [23:0]        y_sat;
    logic signed [41:0] lerp_v;
    logic signed [41:0] o_v;

    assign w_sum  = r_acc + (r_prod <<< 32);
    assign x_wide = $signed(w_sum[65:16]);
    assign y_wide = $signed(w_sum[65:24]);
    assign lerp_v = $signed({{10{r_xp[31]}}, r_xp}) + $signed(r_prod[65:24]);
    assign o_v    = (lerp_v <<< 3) + (lerp_v <<< 1) - OUT_OFS;

    always_comb begin
        if (x_wide > 50'sd2147483647) begin
            x_sat = 32'sh7FFF_FFFF;
        end else if (x_wide < -50'sd2147483648) begin
            x_sat = 32'sh8000_0000;
        end else begin
            x_sat = x_wide[31:0];
        end
        if (y_wide > 42'sd8388607) begin
            y_sat = 24'h7F_FFFF;
        end else if (y_wide < -42'sd8388608) begin
            y_sat = 24'h80_0000;
        end else begin
            y_sat = y_wide[23:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rk       <= 19'd196608;
            r_pk       <= '0;
            r_vk       <= 20'd7;
            r_sp       <= 31'd89478;
            r_phase    <= '0;
            r_xc       <= 32'(X_INIT);
            r_xp       <= 32'(X_INIT);
            r_btn_high <= 1'b1;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_R_KNOB:        r_rk <= i_cfg_wdata[18:0];
                    CFG_PITCH_KNOB:    r_pk <= i_cfg_wdata[15:0];
                    CFG_VOL_KNOB:      r_vk <= i_cfg_wdata[19:0];
                    CFG_SAMPLE_PERIOD: r_sp <= i_cfg_wdata[30:0];
                endcase
            end
            if (i_cmd.cap == CAP_LOAD) begin
                r_btn_high <= in_btn;
            end
            if (i_cmd.cap == CAP_PHASE) begin
                r_phase <= ph_sum[31:0];
                if (!r_conn || r_trig || ph_sum[32]) begin
                    r_xp <= r_xc;
                end
            end
            if (i_cmd.cap == CAP_XSAT) begin
                r_xc <= x_sat;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul != MUL_NONE) begin
            r_prod <= mul_p;
        end
        unique case (i_cmd.cap)
            CAP_NONE: begin
            end
            CAP_LOAD: begin
                r_pcv  <= in_pitch_cv;
                r_rsum <= $signed({3'b0, r_rk}) + $signed({in_r_cv[20], in_r_cv});
                r_gsum <= $signed({2'b0, r_vk}) + $signed({in_vol_cv[20], in_vol_cv});
                r_conn <= i_in_user[0];
                r_trig <= in_btn && !r_btn_high;
            end
            CAP_OCT: begin
                r_oct <= oct_sum;
            end
            CAP_TAB: begin
                r_n    <= r_oct[22:16];
                r_rem  <= r_oct[EXP_SH-1:0];
                r_tab0 <= EXP_TAB[{1'b0, tab_i0}];
                r_tab1 <= EXP_TAB[tab_i1];
            end
            CAP_MANT: begin
                r_mant <= r_tab0 + r_prod[EXP_SH+31:EXP_SH];
            end
            CAP_Q: begin
                r_q <= r_prod[61:24];
            end
            CAP_PL: begin
                r_p <= r_prod[63:0];
            end
            CAP_PSUM: begin
                r_p <= r_p + {r_prod[31:0], 32'b0};
            end
            CAP_DELTA: begin
                r_delta <= dl_c;
            end
            CAP_PHASE: begin
            end
            CAP_T: begin
                r_w <= $signed(r_prod[65:24]);
            end
            CAP_ACC: begin
                r_acc <= r_prod;
            end
            CAP_XSAT: begin
            end
            CAP_LERP: begin
                r_w <= o_v;
            end
            CAP_OUT: begin
                if (r_conn) begin
                    r_out_sample <= y_sat;
                    r_out_flag   <= 1'b1;
                end else begin
                    r_out_sample <= '0;
                    r_out_flag   <= 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_stat.conn  = r_conn;
    assign o_stat.wrap  = ph_sum[32];
    assign o_out_sample = r_out_sample;
    assign o_out_flag   = r_out_flag;

endmodule

`default_nettype wire

// ----- sv/logistic_map_oscillator.sv -----
// Top level of the logistic map chaotic oscillator: stream ports, settings port, sequencer.
// Depends on lmo_pkg, lmo_ctrl and lmo_dp.
//
// One input request is one audio sample and yields exactly one output request. The result of
// a request is registered after the shortest state sequence when the output is unconnected,
// a longer one when connected and the phase does not wrap, and the longest when the phase
// wraps and the logistic map is iterated; the next input can be accepted in the cycle after
// that, so no new request is taken before the current one is done. This comes from a single
// shared 33 by 33 bit multiplier used in turn by every step of the pitch, map and output
// arithmetic. A finished sample waits in the output register while the next request is
// already being worked on; the block stalls at the end of that request only if the earlier
// sample has still not been taken. Settings may be written only while no request is in flight.
`default_nettype none

module logistic_map_oscillator (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [lmo_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [lmo_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // r_cv [20:0], pitch_cv [41:21], vol_cv [62:42], reset_button [63]
    input  wire logic [lmo_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // output_connected [0]
    input  wire logic [lmo_pkg::IN_TUSER_W-1:0]     s_axis_tuser,
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // out_sample [23:0]
    output logic [lmo_pkg::OUT_TDATA_W-1:0]         m_axis_tdata,
    // out_valid [0]
    output logic [lmo_pkg::OUT_TUSER_W-1:0]         m_axis_tuser
);
    import lmo_pkg::*;

    t_cmd  cmd;
    t_stat stat;
    logic  out_flag;

    lmo_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    lmo_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_data    (s_axis_tdata),
        .i_in_user    (s_axis_tuser),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .o_out_sample (m_axis_tdata),
        .o_out_flag   (out_flag)
    );

    assign m_axis_tuser = out_flag;

endmodule

`default_nettype wire
